/* sv/rwnr_pkg.sv */
`default_nettype none
package rwnr_pkg;
  localparam int REFL_W = 37;
  localparam int RMS_W = 20;
  localparam int WGT_W = 32;
  localparam int RAD_W = 18;
  localparam int DIFF_W = 19;
  localparam int D2_W = 41;
  localparam int PROD_W = 52;
  localparam int SUM_W = 64;
  localparam int WSUM_W = 42;
  localparam int CFG_W = 18;
  localparam logic [7:0] BLOCK_SPLIT = 8'd20;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_MEAN    = 2'd0,
    ST_NEAREST = 2'd1,
    ST_INVALID = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_RADIUS = 1'd0,
    CFG_ASC    = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

/* sv/rwnr_div.sv */
`default_nettype none
module rwnr_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rwnr_pkg::SUM_W-1:0]  num,
  input  wire logic [rwnr_pkg::WSUM_W-1:0] den,
  output rwnr_pkg::div_ctl_t               ctl,
  output logic [rwnr_pkg::SUM_W-1:0]       quo
);
  import rwnr_pkg::*;

  logic [SUM_W-1:0] q_r, q_nxt;
  logic [WSUM_W:0] rem_r, rem_nxt;
  logic [WSUM_W-1:0] den_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [WSUM_W:0] sh;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    sh = {rem_r[WSUM_W-1:0], q_r[SUM_W-1]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 7'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
  assign quo = q_r;
endmodule
`default_nettype wire

/* sv/radius_weighted_neighbor_regression_unit.sv */
`default_nettype none
// Fixed-radius neighbor regression. op 0 loads one model entry, op 1 clears the
// table, op 2 queries a pixel and yields one item. A query walks every stored
// entry through one registered distance/accumulate pipeline, one entry per cycle
// from a single memory read port, then, if the weighted sum is nonzero, runs a
// restoring divider at one bit per cycle. A query with a negative reflectance
// returns on the next cycle with status 2. No entry within radius gives roughness
// 0, status 3. The table has no clearing pass; only entries below the fill count
// are read. in_stall is high while busy or while a result waits.
module radius_weighted_neighbor_regression_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [rwnr_pkg::REFL_W-1:0] in_refl_nadir,
  input  wire logic signed [rwnr_pkg::REFL_W-1:0] in_refl_aft,
  input  wire logic signed [rwnr_pkg::REFL_W-1:0] in_refl_fwd,
  input  wire logic [rwnr_pkg::RMS_W-1:0]    in_entry_rms,
  input  wire logic [rwnr_pkg::WGT_W-1:0]    in_entry_weight,
  input  wire logic [7:0]                    in_entry_block,
  input  wire logic                          in_entry_ascending,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [rwnr_pkg::REFL_W-1:0] out_roughness,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [rwnr_pkg::CFG_W-1:0]    cfg_data
);
  import rwnr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 3 * REFL_W + RMS_W + WGT_W + 2;

  // configuration
  logic [RAD_W-1:0] radius_r;
  logic asc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1638);
      asc_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RADIUS) radius_r <= cfg_data[RAD_W-1:0];
      else asc_r <= cfg_data[0];
    end
  end

  // model table: one write port, one registered read port
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic in_acc, out_acc;
  logic do_load;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign do_load = in_acc && (in_op == OP_LOAD) && (count_r < CW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (do_load)
      mem[count_r[AW-1:0]] <= {in_refl_nadir, in_refl_aft, in_refl_fwd, in_entry_rms,
                               in_entry_weight, in_entry_ascending,
                               (in_entry_block < BLOCK_SPLIT)};
    rd_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (in_acc && in_op == OP_CLEAR) count_r <= '0;
    else if (do_load) count_r <= count_r + CW'(1);
  end

  // query registers
  logic signed [REFL_W-1:0] qn_r, qa_r, qf_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qn_r <= in_refl_nadir;
      qa_r <= in_refl_aft;
      qf_r <= in_refl_fwd;
    end
  end

  // pipeline stage 1: entry from memory -> abs diffs
  logic v1_r, v2_r, v3_r;
  logic signed [REFL_W-1:0] en, ea, ef;
  logic [RMS_W-1:0] erms;
  logic [WGT_W-1:0] ewgt;
  logic elow, easc, straight;
  logic signed [REFL_W:0] dn, db, dc;
  logic [REFL_W:0] an, ab, ac;
  assign {en, ea, ef, erms, ewgt, easc, elow} = rd_r;
  assign straight = asc_r ? (!elow && easc) : (elow || !easc);
  assign dn = REFL_W'(0) + {qn_r[REFL_W-1], qn_r} - {en[REFL_W-1], en};
  assign db = {straight ? qa_r[REFL_W-1] : qf_r[REFL_W-1], straight ? qa_r : qf_r}
              - {ea[REFL_W-1], ea};
  assign dc = {straight ? qf_r[REFL_W-1] : qa_r[REFL_W-1], straight ? qf_r : qa_r}
              - {ef[REFL_W-1], ef};
  assign an = dn[REFL_W] ? -dn : dn;
  assign ab = db[REFL_W] ? -db : db;
  assign ac = dc[REFL_W] ? -dc : dc;

  logic [DIFF_W-1:0] a1_r, b1_r, c1_r;
  logic near1_r;
  logic [RMS_W-1:0] rms1_r, rms2_r, rms3_r;
  logic [WGT_W-1:0] w1_r, w2_r;
  always_ff @(posedge clk) begin
    near1_r <= (an[REFL_W:DIFF_W] == '0) && (ab[REFL_W:DIFF_W] == '0)
               && (ac[REFL_W:DIFF_W] == '0);
    a1_r <= an[DIFF_W-1:0];
    b1_r <= ab[DIFF_W-1:0];
    c1_r <= ac[DIFF_W-1:0];
    rms1_r <= erms;
    w1_r <= ewgt;
  end

  // stage 2: squares
  logic [2*DIFF_W-1:0] sa_r, sb_r, sc_r;
  logic near2_r;
  always_ff @(posedge clk) begin
    sa_r <= a1_r * a1_r;
    sb_r <= b1_r * b1_r;
    sc_r <= c1_r * c1_r;
    near2_r <= near1_r;
    rms2_r <= rms1_r;
    w2_r <= w1_r;
  end

  // stage 3: distance, product
  logic [D2_W-1:0] d2_r;
  logic [PROD_W-1:0] prod_r;
  logic [2*RAD_W-1:0] r2_r;
  logic near3_r;
  logic [WGT_W-1:0] w3_r;
  always_ff @(posedge clk) begin
    d2_r <= D2_W'(sa_r) + D2_W'(sb_r) + D2_W'(sc_r);
    prod_r <= w2_r * rms2_r;
    near3_r <= near2_r;
    rms3_r <= rms2_r;
    w3_r <= w2_r;
    r2_r <= radius_r * radius_r;
  end

  // accumulate
  logic [SUM_W-1:0] sum_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [D2_W-1:0] best_r;
  logic [RMS_W-1:0] brms_r;
  logic any_r;
  logic hit;
  assign hit = v3_r && near3_r && (d2_r < D2_W'(r2_r));

  state_t state_r, state_nxt;
  logic div_start;
  div_ctl_t dctl;
  logic [SUM_W-1:0] quo;
  logic oval_r, oval_nxt;
  logic signed [REFL_W-1:0] orough_r, orough_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic clr_acc;
  logic neg;
  assign neg = in_refl_nadir[REFL_W-1] || in_refl_aft[REFL_W-1] || in_refl_fwd[REFL_W-1];

  always_ff @(posedge clk) begin
    if (clr_acc) begin
      sum_r <= '0;
      wsum_r <= '0;
      any_r <= 1'b0;
    end else if (hit) begin
      sum_r <= sum_r + SUM_W'(prod_r);
      wsum_r <= wsum_r + WSUM_W'(w3_r);
      if (!any_r || d2_r < best_r) begin
        best_r <= d2_r;
        brms_r <= rms3_r;
      end
      any_r <= 1'b1;
    end
  end

  rwnr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_r), .den(wsum_r),
    .ctl(dctl), .quo(quo)
  );

  // sequencer
  logic v0;
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    oval_nxt = oval_r;
    orough_nxt = orough_r;
    ostat_nxt = ostat_r;
    div_start = 1'b0;
    clr_acc = 1'b0;
    v0 = 1'b0;
    in_stall = 1'b1;
    if (out_acc) oval_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = oval_r;
        idx_nxt = '0;
        if (in_acc && in_op == OP_QUERY) begin
          clr_acc = 1'b1;
          if (neg) begin
            oval_nxt = 1'b1;
            ostat_nxt = ST_INVALID;
            orough_nxt = in_refl_nadir[REFL_W-1] ? in_refl_nadir :
                         (in_refl_aft[REFL_W-1] ? in_refl_aft : in_refl_fwd);
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < count_r) begin
          v0 = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          if (!any_r) begin
            oval_nxt = 1'b1;
            ostat_nxt = ST_NONE;
            orough_nxt = '0;
            state_nxt = S_OUT;
          end else if (sum_r == '0) begin
            oval_nxt = 1'b1;
            ostat_nxt = ST_NEAREST;
            orough_nxt = REFL_W'(brms_r);
            state_nxt = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (dctl.done) begin
          oval_nxt = 1'b1;
          ostat_nxt = ST_MEAN;
          orough_nxt = quo[REFL_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // v0 means a read was issued this cycle; data appears in rd_r next cycle
  logic vrd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      oval_r <= 1'b0;
      vrd_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      oval_r <= oval_nxt;
      vrd_r <= v0;
      v1_r <= vrd_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    orough_r <= orough_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_valid = oval_r;
  assign out_roughness = orough_r;
  assign out_status = ostat_r;

  // drain must wait for the pipeline, including the read stage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.busy |-> (state_r == S_DIV)) else $error("divider outside div state");
  a_hit_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (state_r == S_SCAN || state_r == S_DRAIN)) else $error("stray hit");
endmodule
`default_nettype wire

/* tb/tb_radius_weighted_neighbor_regression_unit.sv */
`timescale 1ns / 100ps
module tb_radius_weighted_neighbor_regression_unit;
  import rwnr_pkg::*;

  localparam int DEPTH = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_NONE;
  logic signed [REFL_W-1:0] in_refl_nadir = '0;
  logic signed [REFL_W-1:0] in_refl_aft = '0;
  logic signed [REFL_W-1:0] in_refl_fwd = '0;
  logic [RMS_W-1:0] in_entry_rms = '0;
  logic [WGT_W-1:0] in_entry_weight = '0;
  logic [7:0] in_entry_block = '0;
  logic in_entry_ascending = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [REFL_W-1:0] out_roughness;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  radius_weighted_neighbor_regression_unit #(.TABLE_DEPTH(DEPTH)) uut (.*);

  always #2 clk = ~clk;

  // predictor state: stored model table and registers
  logic signed [REFL_W-1:0] tbl_nadir [DEPTH];
  logic signed [REFL_W-1:0] tbl_aft [DEPTH];
  logic signed [REFL_W-1:0] tbl_fwd [DEPTH];
  logic [RMS_W-1:0] tbl_rms [DEPTH];
  logic [WGT_W-1:0] tbl_weight [DEPTH];
  logic tbl_low [DEPTH];
  logic tbl_asc [DEPTH];
  int fill;
  logic [RAD_W-1:0] radius_q;
  logic asc_pass;

  // expected roughness/status pairs, oldest first
  logic [REFL_W-1:0] want_rough [$];
  status_t want_status [$];
  int errors = 0;
  int seen = 0;
  int stall_left = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [38:0] mag(input logic signed [REFL_W-1:0] a,
                                      input logic signed [REFL_W-1:0] b);
    logic signed [38:0] d;
    d = 39'(a) - 39'(b);
    return d < 0 ? -d : d;
  endfunction

  // compute the estimate for a query and queue it
  task automatic predict_query(input logic signed [REFL_W-1:0] qn, qa, qf);
    logic [127:0] num;
    logic [63:0] wsum, d2, best, r2;
    logic [38:0] da, db, dc;
    logic [RMS_W-1:0] best_rms;
    logic straight, any;
    if (qn < 0 || qa < 0 || qf < 0) begin
      want_rough.push_back(qn < 0 ? qn : (qa < 0 ? qa : qf));
      want_status.push_back(ST_INVALID);
      return;
    end
    num = 0; wsum = 0; best = 0; best_rms = 0; any = 0;
    r2 = 64'(radius_q) * 64'(radius_q);
    for (int k = 0; k < fill; k++) begin
      straight = asc_pass ? (!tbl_low[k] && tbl_asc[k]) : (tbl_low[k] || !tbl_asc[k]);
      da = mag(qn, tbl_nadir[k]);
      db = mag(straight ? qa : qf, tbl_aft[k]);
      dc = mag(straight ? qf : qa, tbl_fwd[k]);
      if (da >= (1 << 19) || db >= (1 << 19) || dc >= (1 << 19)) continue;
      d2 = 64'(da) * da + 64'(db) * db + 64'(dc) * dc;
      if (d2 >= r2) continue;
      num += 128'(64'(tbl_weight[k]) * tbl_rms[k]);
      wsum += tbl_weight[k];
      if (!any || d2 < best) begin
        best = d2;
        best_rms = tbl_rms[k];
        any = 1;
      end
    end
    if (!any) begin
      want_rough.push_back('0);
      want_status.push_back(ST_NONE);
    end else if (num == 0) begin
      want_rough.push_back(REFL_W'(best_rms));
      want_status.push_back(ST_NEAREST);
    end else begin
      want_rough.push_back(REFL_W'(num / wsum));
      want_status.push_back(ST_MEAN);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one item and wait for acceptance; prediction at acceptance
  // valid stays high after acceptance so the next item can follow at once
  task automatic send_item(input op_t op, input logic signed [REFL_W-1:0] n, a, f,
                           input logic [RMS_W-1:0] rms, input logic [WGT_W-1:0] w,
                           input logic [7:0] blk, input logic asc, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_refl_nadir <= n;
    in_refl_aft <= a;
    in_refl_fwd <= f;
    in_entry_rms <= rms;
    in_entry_weight <= w;
    in_entry_block <= blk;
    in_entry_ascending <= asc;
    do @(posedge clk); while (in_stall);
    case (op)
      OP_LOAD: if (fill < DEPTH) begin
        tbl_nadir[fill] = n; tbl_aft[fill] = a; tbl_fwd[fill] = f;
        tbl_rms[fill] = rms; tbl_weight[fill] = w;
        tbl_low[fill] = blk < BLOCK_SPLIT; tbl_asc[fill] = asc;
        fill++;
      end
      OP_CLEAR: fill = 0;
      OP_QUERY: predict_query(n, a, f);
      default: ;
    endcase
  endtask

  // result checker with random stalls, mostly short and a few long
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen++;
      if (want_rough.size() == 0) report("result with nothing expected");
      else begin
        logic [REFL_W-1:0] r;
        status_t s;
        r = want_rough.pop_front();
        s = want_status.pop_front();
        if (out_roughness !== r)
          report($sformatf("roughness %h want %h", out_roughness, r));
        if (out_status !== s)
          report($sformatf("status %0d want %0d", out_status, s));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (want_rough.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RADIUS) radius_q = v;
    else asc_pass = v[0];
  endtask

  function automatic logic signed [REFL_W-1:0] near_refl(input logic signed [REFL_W-1:0] c,
                                                        input int spread);
    logic signed [REFL_W-1:0] v;
    v = c + $signed(37'($urandom_range(0, 2 * spread))) - spread;
    return v < 0 ? '0 : v;
  endfunction

  function automatic logic signed [REFL_W-1:0] any_refl();
    case ($urandom_range(0, 3))
      0: return -$signed(37'({$urandom, $urandom} % 64'h10_0000_0000)) - 1;
      1: return {1'b1, 36'({$urandom, $urandom})};
      default: return 37'($urandom_range(0, 262143));
    endcase
  endfunction

  // directed: extremes, flags, pairing cases, fallbacks
  task automatic test_directed();
    send_item(OP_QUERY, 100, 100, 100, 0, 0, 0, 0, 0);               // empty table
    send_item(OP_LOAD, 1000, 2000, 3000, 20'hFFFFF, 32'hFFFFFFFF, 0, 0, 0);
    send_item(OP_LOAD, 1000, 3000, 2000, 65536, 65536, 8'd20, 1, 0);
    send_item(OP_LOAD, 1010, 2000, 3000, 12345, 0, 8'd19, 1, 0);
    send_item(OP_LOAD, 262143, 262143, 262143, 777, 0, 8'd255, 0, 0);
    send_item(OP_LOAD, -37'sd68719476736, 5, 5, 1, 1, 8'd21, 1, 0); // out of range stored
    send_item(OP_QUERY, 1000, 2000, 3000, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 262143, 262143, 262143, 0, 0, 0, 0, 0);     // weight zero: nearest
    send_item(OP_QUERY, -37'sd1, -37'sd2, -37'sd3, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 5, -37'sd68719476736, -37'sd7, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 5, 5, -37'sd9, 20'hFFFFF, 32'hFFFFFFFF, 8'hFF, 1, 0);
    send_item(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_reg(CFG_ASC, 1);
    write_reg(CFG_RADIUS, 0);
    send_item(OP_QUERY, 1000, 2000, 3000, 0, 0, 0, 0, 0);           // radius zero: none
    wait_idle();
    write_reg(CFG_RADIUS, 18'h3FFFF);
    send_item(OP_QUERY, 1000, 3000, 2000, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 131072, 131072, 131072, 0, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 1000, 2000, 3000, 0, 0, 0, 0, 0);
    wait_idle();
  endtask

  // random loads near a center mixed with queries near it; a clear moves the center
  task automatic test_random_phase(input int items, input logic [CFG_W-1:0] rad,
                                   input logic asc);
    logic signed [REFL_W-1:0] cn, ca, cf;
    int r;
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_ASC, CFG_W'(asc));
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1);
    cn = 37'($urandom_range(0, 262143)); ca = 37'($urandom_range(0, 262143));
    cf = 37'($urandom_range(0, 262143));
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(OP_LOAD, near_refl(cn, 3000), near_refl(ca, 3000), near_refl(cf, 3000),
                  $urandom_range(0, 4) == 0 ? 20'($urandom) : 20'($urandom_range(0, 200000)),
                  $urandom_range(0, 5) == 0 ? 32'd0 : $urandom,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      else if (r < 50)
        send_item(OP_LOAD, any_refl(), any_refl(), any_refl(), 20'($urandom), $urandom,
                  8'($urandom), 1'($urandom), 1'b1);
      else if (r < 85)
        send_item(OP_QUERY, near_refl(cn, 4000), near_refl(ca, 4000), near_refl(cf, 4000),
                  20'($urandom), $urandom, 8'($urandom), 1'($urandom), 1'b1);
      else if (r < 93)
        send_item(OP_QUERY, any_refl(), any_refl(), any_refl(), 0, 0, 0, 0, 1'b1);
      else if (r < 96)
        send_item(OP_NONE, any_refl(), any_refl(), any_refl(), 0, 0, 0, 0, 1'b1);
      else begin
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        cn = 37'($urandom_range(0, 262143));
      end
    end
    wait_idle();
  endtask

  // a larger table under a wide radius, many entries in range at once
  task automatic test_large_table();
    write_reg(CFG_RADIUS, 18'h3FFFF);
    write_reg(CFG_ASC, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 96; i++)
      send_item(OP_LOAD, 37'($urandom_range(0, 262143)), 37'($urandom_range(0, 262143)),
                37'($urandom_range(0, 262143)), 20'($urandom),
                32'($urandom_range(0, 65535)), 8'($urandom), 1'($urandom), 1'b0);
    send_item(OP_QUERY, 100000, 100000, 100000, 0, 0, 0, 0, 1'b1);
    send_item(OP_QUERY, 0, 262143, 0, 0, 0, 0, 0, 1'b1);
    wait_idle();
  endtask

  initial begin
    radius_q = 18'd1638;
    asc_pass = 1'b0;
    fill = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(105, 18'd1638, 0);
    test_random_phase(105, 18'd6000, 1);
    test_random_phase(105, 18'h3FFFF, 0);
    test_random_phase(105, 18'd300, 1);
    test_large_table();
    repeat (50) @(posedge clk);
    if (errors == 0 && want_rough.size() == 0) $display("PASS");
    else begin
      if (want_rough.size() != 0) report("expected results left over");
      $display("FAIL");
    end
    $finish;
  end

  // generous fixed limit on the whole run
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
